// ===== sv/lpm_pkg.sv =====
// ----------------------------------------------------------------------------
// lpm_pkg
// shared constants, types and helpers of the ipv4 longest prefix match table
// ----------------------------------------------------------------------------
package lpm_pkg;

    localparam int ENTRIES = 64;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RCNT_W  = $clog2(ENTRIES + 1);
    localparam int STAT_W  = 48;
    localparam int LEN_W   = 6;
    localparam int KIND_W  = 3;
    localparam int KEY_W   = 32 + LEN_W + KIND_W;
    localparam int PAY_W   = 32 + 32 + 8;
    localparam logic [LEN_W-1:0] MAX_LEN = 6'd32;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_DEL    = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_SPARE  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_MISS   = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;
    localparam logic [1:0] ST_BADLEN = 2'd3;

    typedef struct packed {
        logic clear;
        logic step;
        logic is_add;
        logic is_lookup;
    } match_ctl_t;

    typedef struct packed {
        logic              hit_vld;
        logic [IDX_W-1:0]  hit_idx;
        logic              free_vld;
        logic [IDX_W-1:0]  free_idx;
        logic              best_vld;
        logic [IDX_W-1:0]  best_idx;
        logic [LEN_W-1:0]  best_len;
        logic [KIND_W-1:0] best_kind;
    } match_trk_t;

    function automatic logic [31:0] len_mask(input logic [LEN_W-1:0] len);
        logic [31:0] m;
        if (len == '0)
        begin
            m = '0;
        end
        else if (len >= MAX_LEN)
        begin
            m = '1;
        end
        else
        begin
            m = 32'hFFFF_FFFF << (6'd32 - len);
        end
        return m;
    endfunction

endpackage

// ===== sv/ipv4_lpm_route_table_core.sv =====
// ----------------------------------------------------------------------------
// ipv4_lpm_route_table_core
// flat ipv4 route table with add, delete and longest prefix match lookup
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+----------------------------------------
//  command  | in_valid / in_ready  | cmd address prefix_length gateway
//           |                      | out_interface distance origin_kind
//  result   | out_valid / out_ready| status found hop_out iface_out
//           |                      | distance_out kind_out match_length
//           |                      | route_total lookup_total hit_total
//           |                      | miss_total
//
//  add, delete and lookup read the key ram once per slot through one comparator,
//  then pass the fin and done states to the result register; no new item is
//  taken until that result register is loaded
//  a bad length on add or delete, or the unused code, goes straight to done
//  reset clears the slot valid flags and all counters at once
//  a result waiting on out_ready holds the next item back only at its end
// ----------------------------------------------------------------------------
module ipv4_lpm_route_table_core
    import lpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        cmd,
    input  logic [31:0]       address,
    input  logic [5:0]        prefix_length,
    input  logic [31:0]       gateway,
    input  logic [31:0]       out_interface,
    input  logic [7:0]        distance,
    input  logic [2:0]        origin_kind,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        status,
    output logic              found,
    output logic [31:0]       hop_out,
    output logic [31:0]       iface_out,
    output logic [7:0]        distance_out,
    output logic [2:0]        kind_out,
    output logic [5:0]        match_length,
    output logic [6:0]        route_total,
    output logic [47:0]       lookup_total,
    output logic [47:0]       hit_total,
    output logic [47:0]       miss_total
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_DONE = 3'd3;

    logic [2:0]        state_reg;
    logic [2:0]        state_next;

    logic [1:0]        cmd_reg;
    logic [31:0]       addr_reg;
    logic [31:0]       pfx_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [31:0]       gw_reg;
    logic [31:0]       ifc_reg;
    logic [7:0]        dist_reg;
    logic [KIND_W-1:0] kind_reg;

    logic [IDX_W:0]    issue_cnt_reg;
    logic              cmp_vld_reg;
    logic [IDX_W-1:0]  cmp_idx_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic [RCNT_W-1:0] route_cnt_reg;
    logic [STAT_W-1:0] lookup_cnt_reg;
    logic [STAT_W-1:0] hit_cnt_reg;
    logic [STAT_W-1:0] miss_cnt_reg;

    logic [1:0]        res_status_reg;
    logic              res_found_reg;
    logic [LEN_W-1:0]  res_len_reg;
    logic [KIND_W-1:0] res_kind_reg;

    logic              out_valid_reg;
    logic [1:0]        status_reg;
    logic              found_reg;
    logic [31:0]       hop_reg;
    logic [31:0]       iface_reg;
    logic [7:0]        dist_out_reg;
    logic [2:0]        kind_out_reg;
    logic [5:0]        mlen_reg;
    logic [6:0]        route_out_reg;
    logic [47:0]       lookup_out_reg;
    logic [47:0]       hit_out_reg;
    logic [47:0]       miss_out_reg;

    logic              accept;
    logic              issue;
    logic              last_cmp;
    logic              out_load;
    logic              is_add;
    logic              is_del;
    logic              is_lookup;
    logic              bad_len;
    logic              do_write;
    logic [IDX_W-1:0]  wr_idx;
    logic [KEY_W-1:0]  key_rd;
    logic [PAY_W-1:0]  pay_rd;
    match_ctl_t        mctl;
    match_trk_t        trk;

    assign accept    = in_valid && in_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign issue     = (state_reg == S_SCAN) && (issue_cnt_reg < (IDX_W+1)'(ENTRIES));
    assign last_cmp  = cmp_vld_reg && (cmp_idx_reg == IDX_W'(ENTRIES - 1));
    assign out_load  = (state_reg == S_DONE) && (!out_valid_reg || out_ready);
    assign is_add    = (cmd_reg == CMD_ADD);
    assign is_del    = (cmd_reg == CMD_DEL);
    assign is_lookup = (cmd_reg == CMD_LOOKUP);
    assign bad_len   = (cmd inside {CMD_ADD, CMD_DEL}) && (prefix_length > MAX_LEN);

    // add target: matching route first, then lowest free slot
    assign wr_idx   = trk.hit_vld ? trk.hit_idx : trk.free_idx;
    assign do_write = (state_reg == S_FIN) && is_add && (trk.hit_vld || trk.free_vld);

    assign mctl.clear     = accept;
    assign mctl.step      = cmp_vld_reg;
    assign mctl.is_add    = is_add;
    assign mctl.is_lookup = is_lookup;

    lpm_ram #(
        .WIDTH (KEY_W),
        .DEPTH (ENTRIES)
    ) u_key_ram (
        .clk     (clk),
        .wr_en   (do_write),
        .wr_addr (wr_idx),
        .wr_data ({pfx_reg, len_reg, kind_reg}),
        .rd_en   (issue),
        .rd_addr (issue_cnt_reg[IDX_W-1:0]),
        .rd_data (key_rd)
    );

    lpm_ram #(
        .WIDTH (PAY_W),
        .DEPTH (ENTRIES)
    ) u_pay_ram (
        .clk     (clk),
        .wr_en   (do_write),
        .wr_addr (wr_idx),
        .wr_data ({gw_reg, ifc_reg, dist_reg}),
        .rd_en   ((state_reg == S_FIN) && is_lookup),
        .rd_addr (trk.best_idx),
        .rd_data (pay_rd)
    );

    lpm_match u_match (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (mctl),
        .addr       (addr_reg),
        .pfx        (pfx_reg),
        .len        (len_reg),
        .kind       (kind_reg),
        .slot_valid (valid_reg[cmp_idx_reg]),
        .slot_idx   (cmp_idx_reg),
        .slot_key   (key_rd),
        .trk        (trk)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (bad_len || (cmd == CMD_SPARE))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (last_cmp)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd;
            addr_reg <= address;
            pfx_reg  <= address & len_mask(prefix_length);
            len_reg  <= prefix_length;
            gw_reg   <= gateway;
            ifc_reg  <= out_interface;
            dist_reg <= distance;
            kind_reg <= origin_kind;
        end
    end

    // control, slot flags and counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            issue_cnt_reg  <= '0;
            cmp_vld_reg    <= 1'b0;
            cmp_idx_reg    <= '0;
            valid_reg      <= '0;
            route_cnt_reg  <= '0;
            lookup_cnt_reg <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
            res_status_reg <= ST_OK;
            res_found_reg  <= 1'b0;
            res_len_reg    <= '0;
            res_kind_reg   <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cmp_vld_reg <= issue;
            if (issue)
            begin
                cmp_idx_reg   <= issue_cnt_reg[IDX_W-1:0];
                issue_cnt_reg <= issue_cnt_reg + 1'b1;
            end
            if (accept)
            begin
                issue_cnt_reg  <= '0;
                res_found_reg  <= 1'b0;
                res_len_reg    <= '0;
                res_kind_reg   <= '0;
                res_status_reg <= bad_len ? ST_BADLEN : ST_OK;
            end
            if (state_reg == S_FIN)
            begin
                if (is_add)
                begin
                    if (trk.hit_vld || trk.free_vld)
                    begin
                        valid_reg[wr_idx] <= 1'b1;
                        if (!trk.hit_vld)
                        begin
                            route_cnt_reg <= route_cnt_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        res_status_reg <= ST_FULL;
                    end
                end
                else if (is_del)
                begin
                    if (trk.hit_vld)
                    begin
                        valid_reg[trk.hit_idx] <= 1'b0;
                        route_cnt_reg <= route_cnt_reg - 1'b1;
                    end
                    else
                    begin
                        res_status_reg <= ST_MISS;
                    end
                end
                else
                begin
                    lookup_cnt_reg <= lookup_cnt_reg + 1'b1;
                    if (trk.best_vld)
                    begin
                        hit_cnt_reg   <= hit_cnt_reg + 1'b1;
                        res_found_reg <= 1'b1;
                        res_len_reg   <= trk.best_len;
                        res_kind_reg  <= trk.best_kind;
                    end
                    else
                    begin
                        miss_cnt_reg   <= miss_cnt_reg + 1'b1;
                        res_status_reg <= ST_MISS;
                    end
                end
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg     <= res_status_reg;
            found_reg      <= res_found_reg;
            hop_reg        <= res_found_reg ? pay_rd[PAY_W-1 -: 32] : '0;
            iface_reg      <= res_found_reg ? pay_rd[8 +: 32] : '0;
            dist_out_reg   <= res_found_reg ? pay_rd[7:0] : '0;
            kind_out_reg   <= res_kind_reg;
            mlen_reg       <= res_len_reg;
            route_out_reg  <= 7'(route_cnt_reg);
            lookup_out_reg <= lookup_cnt_reg;
            hit_out_reg    <= hit_cnt_reg;
            miss_out_reg   <= miss_cnt_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign found        = found_reg;
    assign hop_out      = hop_reg;
    assign iface_out    = iface_reg;
    assign distance_out = dist_out_reg;
    assign kind_out     = kind_out_reg;
    assign match_length = mlen_reg;
    assign route_total  = route_out_reg;
    assign lookup_total = lookup_out_reg;
    assign hit_total    = hit_out_reg;
    assign miss_total   = miss_out_reg;

endmodule

// ===== sv/lpm_ram.sv =====
// ----------------------------------------------------------------------------
// lpm_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module lpm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic                                         rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== sv/lpm_match.sv =====
// ----------------------------------------------------------------------------
// lpm_match
// shared masked comparator with first-hit, first-free and best-match tracking
// ----------------------------------------------------------------------------
module lpm_match
    import lpm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  match_ctl_t        ctl,
    input  logic [31:0]       addr,
    input  logic [31:0]       pfx,
    input  logic [LEN_W-1:0]  len,
    input  logic [KIND_W-1:0] kind,
    input  logic              slot_valid,
    input  logic [IDX_W-1:0]  slot_idx,
    input  logic [KEY_W-1:0]  slot_key,
    output match_trk_t        trk
);

    match_trk_t        trk_reg;
    match_trk_t        trk_next;
    logic [31:0]       slot_prefix;
    logic [LEN_W-1:0]  slot_len;
    logic [KIND_W-1:0] slot_kind;
    logic              key_hit;
    logic              lkp_hit;

    assign slot_prefix = slot_key[KEY_W-1 -: 32];
    assign slot_len    = slot_key[KIND_W +: LEN_W];
    assign slot_kind   = slot_key[KIND_W-1:0];

    assign key_hit = slot_valid && (slot_len == len) && (slot_prefix == pfx)
                     && (ctl.is_add || (slot_kind == kind));
    assign lkp_hit = slot_valid && ((addr & len_mask(slot_len)) == slot_prefix)
                     && (!trk_reg.best_vld || (slot_len > trk_reg.best_len));

    always_comb
    begin
        trk_next = trk_reg;
        if (ctl.clear)
        begin
            trk_next.hit_vld  = 1'b0;
            trk_next.free_vld = 1'b0;
            trk_next.best_vld = 1'b0;
        end
        else if (ctl.step)
        begin
            if (key_hit && !trk_reg.hit_vld)
            begin
                trk_next.hit_vld = 1'b1;
                trk_next.hit_idx = slot_idx;
            end
            if (!slot_valid && !trk_reg.free_vld)
            begin
                trk_next.free_vld = 1'b1;
                trk_next.free_idx = slot_idx;
            end
            if (ctl.is_lookup && lkp_hit)
            begin
                trk_next.best_vld  = 1'b1;
                trk_next.best_idx  = slot_idx;
                trk_next.best_len  = slot_len;
                trk_next.best_kind = slot_kind;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            trk_reg <= '0;
        end
        else
        begin
            trk_reg <= trk_next;
        end
    end

    assign trk = trk_reg;

endmodule

// ===== sv/lpm_checker.sv =====
// ----------------------------------------------------------------------------
// lpm_checker
// port level checks of the route table core, bound to the top level
// ----------------------------------------------------------------------------
module lpm_checker
    import lpm_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [1:0]  status,
    input logic        found,
    input logic [5:0]  match_length,
    input logic [47:0] lookup_total,
    input logic [47:0] hit_total,
    input logic [47:0] miss_total
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(found))
        else $error("result changed while stalled");

    // one item at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready right after an accepted item");

    // route fields only on a hit
    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> !found && (match_length == '0))
        else $error("route fields set without a hit");

    a_hit_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && found |-> (status == ST_OK) && (match_length <= MAX_LEN))
        else $error("bad hit result");

    // every lookup is a hit or a miss
    a_totals: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (48'(hit_total + miss_total) == lookup_total))
        else $error("lookup totals disagree");

endmodule

bind ipv4_lpm_route_table_core lpm_checker u_lpm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .found        (found),
    .match_length (match_length),
    .lookup_total (lookup_total),
    .hit_total    (hit_total),
    .miss_total   (miss_total)
);

// ===== test/tb_ipv4_lpm_route_table_core.sv =====
// ----------------------------------------------------------------------------
// tb_ipv4_lpm_route_table_core
// self-checking bench for the flat ipv4 longest prefix match route table
//
// adds, deletes and lookups go in over the command channel. A scoreboard
// keeps its own copy of the route table and the lookup counters, predicts
// the reply to every accepted command and compares each reply, field by
// field, with the oldest prediction. A directed run covers the corner cases,
// then random traffic built around a small pool of networks fills, churns
// and drains the table under changing sender and receiver throttling.
// ----------------------------------------------------------------------------
import lpm_pkg::*;

typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [31:0] hop;
    logic [31:0] iface;
    logic [7:0]  admin;
    logic [2:0]  kind;
    logic [5:0]  mlen;
    logic [6:0]  routes;
    logic [47:0] lookups;
    logic [47:0] hits;
    logic [47:0] misses;
} route_reply_t;

class route_table_scoreboard;
    bit           in_use [ENTRIES];
    logic [31:0]  stored_prefix [ENTRIES];
    logic [5:0]   stored_len [ENTRIES];
    logic [31:0]  stored_hop [ENTRIES];
    logic [31:0]  stored_iface [ENTRIES];
    logic [7:0]   stored_dist [ENTRIES];
    logic [2:0]   stored_kind [ENTRIES];
    int           route_count;
    logic [47:0]  lookup_count;
    logic [47:0]  hit_count;
    logic [47:0]  miss_count;
    route_reply_t predicted_replies [$];
    int           errors;

    function new();
        foreach (in_use[i])
        begin
            in_use[i] = 1'b0;
        end
        route_count  = 0;
        lookup_count = '0;
        hit_count    = '0;
        miss_count   = '0;
        errors       = 0;
    endfunction

    function logic [31:0] net_mask(input logic [5:0] len);
        return ~(32'hFFFF_FFFF >> len);
    endfunction

    // predict the reply of one accepted command and update the table copy
    function void note_command(input logic [1:0] op, input logic [31:0] addr,
                               input logic [5:0] len, input logic [31:0] hop,
                               input logic [31:0] iface, input logic [7:0] admin,
                               input logic [2:0] kind);
        route_reply_t r;
        logic [31:0]  masked;
        int           hit_slot;
        int           free_slot;
        int           best;
        int           s;
        r = '0;
        r.status = ST_OK;
        if (op == CMD_ADD || op == CMD_DEL)
        begin
            if (len > MAX_LEN)
            begin
                r.status = ST_BADLEN;
            end
            else
            begin
                masked    = addr & net_mask(len);
                hit_slot  = -1;
                free_slot = -1;
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (in_use[i])
                    begin
                        if (hit_slot < 0 && stored_len[i] == len &&
                            stored_prefix[i] == masked &&
                            (op == CMD_ADD || stored_kind[i] == kind))
                        begin
                            hit_slot = i;
                        end
                    end
                    else if (free_slot < 0)
                    begin
                        free_slot = i;
                    end
                end
                if (op == CMD_ADD)
                begin
                    s = (hit_slot >= 0) ? hit_slot : free_slot;
                    if (s < 0)
                    begin
                        r.status = ST_FULL;
                    end
                    else
                    begin
                        if (hit_slot < 0)
                        begin
                            route_count++;
                        end
                        in_use[s]        = 1'b1;
                        stored_prefix[s] = masked;
                        stored_len[s]    = len;
                        stored_hop[s]    = hop;
                        stored_iface[s]  = iface;
                        stored_dist[s]   = admin;
                        stored_kind[s]   = kind;
                    end
                end
                else if (hit_slot < 0)
                begin
                    r.status = ST_MISS;
                end
                else
                begin
                    in_use[hit_slot] = 1'b0;
                    route_count--;
                end
            end
        end
        else if (op == CMD_LOOKUP)
        begin
            best = -1;
            for (int i = 0; i < ENTRIES; i++)
            begin
                if (in_use[i] && (addr & net_mask(stored_len[i])) == stored_prefix[i] &&
                    (best < 0 || stored_len[i] > stored_len[best]))
                begin
                    best = i;
                end
            end
            lookup_count++;
            if (best < 0)
            begin
                r.status = ST_MISS;
                miss_count++;
            end
            else
            begin
                r.found = 1'b1;
                r.hop   = stored_hop[best];
                r.iface = stored_iface[best];
                r.admin = stored_dist[best];
                r.kind  = stored_kind[best];
                r.mlen  = stored_len[best];
                hit_count++;
            end
        end
        r.routes  = route_count[6:0];
        r.lookups = lookup_count;
        r.hits    = hit_count;
        r.misses  = miss_count;
        predicted_replies.push_back(r);
    endfunction

    function void flag_field(input string name, input logic [47:0] want,
                             input logic [47:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 200)
            begin
                $display("%0t: %s mismatch, expected %0h, actual %0h",
                         $time, name, want, got);
            end
        end
    endfunction

    function void check_result(input route_reply_t got);
        route_reply_t want;
        if (predicted_replies.size() == 0)
        begin
            errors++;
            $display("%0t: reply with nothing expected, expected none, actual status %0d",
                     $time, got.status);
            return;
        end
        want = predicted_replies.pop_front();
        flag_field("status", want.status, got.status);
        flag_field("found", want.found, got.found);
        flag_field("hop_out", want.hop, got.hop);
        flag_field("iface_out", want.iface, got.iface);
        flag_field("distance_out", want.admin, got.admin);
        flag_field("kind_out", want.kind, got.kind);
        flag_field("match_length", want.mlen, got.mlen);
        flag_field("route_total", want.routes, got.routes);
        flag_field("lookup_total", want.lookups, got.lookups);
        flag_field("hit_total", want.hits, got.hits);
        flag_field("miss_total", want.misses, got.misses);
    endfunction

    function int pending();
        return predicted_replies.size();
    endfunction
endclass

module tb_ipv4_lpm_route_table_core;
    import lpm_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [31:0] addr;
        logic [5:0]  len;
        logic [2:0]  kind;
    } route_key_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  cmd = CMD_LOOKUP;
    logic [31:0] address = '0;
    logic [5:0]  prefix_length = '0;
    logic [31:0] gateway = '0;
    logic [31:0] out_interface = '0;
    logic [7:0]  distance = '0;
    logic [2:0]  origin_kind = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [1:0]  status;
    logic        found;
    logic [31:0] hop_out;
    logic [31:0] iface_out;
    logic [7:0]  distance_out;
    logic [2:0]  kind_out;
    logic [5:0]  match_length;
    logic [6:0]  route_total;
    logic [47:0] lookup_total;
    logic [47:0] hit_total;
    logic [47:0] miss_total;

    route_table_scoreboard sb;
    route_key_t  added_routes [$];
    logic [31:0] net_pool [16];
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_req = 1'b0;
    bit          hold_done = 1'b0;
    int          hold_left = 0;

    ipv4_lpm_route_table_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .cmd           (cmd),
        .address       (address),
        .prefix_length (prefix_length),
        .gateway       (gateway),
        .out_interface (out_interface),
        .distance      (distance),
        .origin_kind   (origin_kind),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .found         (found),
        .hop_out       (hop_out),
        .iface_out     (iface_out),
        .distance_out  (distance_out),
        .kind_out      (kind_out),
        .match_length  (match_length),
        .route_total   (route_total),
        .lookup_total  (lookup_total),
        .hit_total     (hit_total),
        .miss_total    (miss_total)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // result side: check accepted replies, then throttle out_ready
    always @(posedge clk)
    begin : result_side
        route_reply_t got;
        if (out_valid && out_ready)
        begin
            got.status  = status;
            got.found   = found;
            got.hop     = hop_out;
            got.iface   = iface_out;
            got.admin   = distance_out;
            got.kind    = kind_out;
            got.mlen    = match_length;
            got.routes  = route_total;
            got.lookups = lookup_total;
            got.hits    = hit_total;
            got.misses  = miss_total;
            sb.check_result(got);
        end
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_req && !hold_done)
        begin
            out_ready <= 1'b0;
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("tb: failure");
        $finish;
    end

    task automatic drive_cmd(input logic [1:0] op, input logic [31:0] addr,
                             input logic [5:0] len, input logic [31:0] hop,
                             input logic [31:0] iface, input logic [7:0] admin,
                             input logic [2:0] kind);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= op;
        address       <= addr;
        prefix_length <= len;
        gateway       <= hop;
        out_interface <= iface;
        distance      <= admin;
        origin_kind   <= kind;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        sb.note_command(op, addr, len, hop, iface, admin, kind);
    endtask

    function automatic logic [5:0] pick_length();
        case ($urandom_range(0, 9))
            0: return 6'd0;
            1: return 6'd32;
            2: return 6'd8;
            3: return 6'd16;
            4: return 6'd24;
            default: return 6'($urandom_range(1, 31));
        endcase
    endfunction

    task automatic issue_random(input int add_w, input int del_w);
        int          roll;
        int          pick;
        logic [1:0]  op;
        logic [31:0] addr;
        logic [31:0] base;
        logic [5:0]  len;
        logic [2:0]  kind;
        route_key_t  key;
        roll = $urandom_range(0, 99);
        base = net_pool[$urandom_range(0, 15)];
        kind = 3'($urandom_range(0, 7));
        op   = CMD_LOOKUP;
        addr = base ^ ($urandom >> $urandom_range(0, 32));
        len  = 6'($urandom_range(0, 63));
        if (roll < add_w)
        begin
            op       = CMD_ADD;
            len      = pick_length();
            addr     = base ^ ($urandom >> $urandom_range(4, 32));
            key.addr = addr;
            key.len  = len;
            key.kind = kind;
            added_routes.push_back(key);
            if (added_routes.size() > 96)
            begin
                void'(added_routes.pop_front());
            end
        end
        else if (roll < add_w + del_w)
        begin
            op = CMD_DEL;
            if (added_routes.size() != 0 && $urandom_range(0, 99) < 85)
            begin
                pick = $urandom_range(0, added_routes.size() - 1);
                key  = added_routes[pick];
                len  = key.len;
                // host bits are don't care for a delete
                addr = key.addr ^ ($urandom & (32'hFFFF_FFFF >> len));
                if ($urandom_range(0, 99) < 75)
                begin
                    kind = key.kind;
                    added_routes.delete(pick);
                end
            end
            else
            begin
                len = pick_length();
            end
        end
        else if (roll >= 95)
        begin
            addr = $urandom;
            case ($urandom_range(0, 2))
                0: op = CMD_SPARE;
                1: op = CMD_ADD;
                default: op = CMD_DEL;
            endcase
            if (op != CMD_SPARE)
            begin
                len = 6'($urandom_range(33, 63));
            end
        end
        drive_cmd(op, addr, len, $urandom, $urandom, 8'($urandom_range(0, 255)), kind);
    endtask

    initial
    begin : stimulus
        int add_w;
        int del_w;
        sb = new();
        foreach (net_pool[i])
        begin
            net_pool[i] = $urandom;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed corner cases
        drive_cmd(CMD_LOOKUP, 32'h0A01_0203, 6'd0, $urandom, $urandom, 8'd0, 3'd0);
        drive_cmd(CMD_ADD, 32'h0A01_0203, 6'd8, 32'hC0A8_0001, 32'd1, 8'd1, 3'd1);
        drive_cmd(CMD_ADD, 32'h0A01_FFFF, 6'd16, 32'hC0A8_0002, 32'd2, 8'd20, 3'd2);
        drive_cmd(CMD_ADD, 32'hDEAD_BEEF, 6'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 3'd7);
        drive_cmd(CMD_ADD, 32'hFFFF_FFFF, 6'd32, 32'h0, 32'h0, 8'h0, 3'd0);
        drive_cmd(CMD_LOOKUP, 32'h0A01_0505, 6'd63, $urandom, $urandom, 8'hFF, 3'd7);
        drive_cmd(CMD_LOOKUP, 32'h0A7F_0000, 6'd0, $urandom, $urandom, 8'd0, 3'd0);
        drive_cmd(CMD_LOOKUP, 32'hFFFF_FFFF, 6'd32, $urandom, $urandom, 8'd0, 3'd0);
        drive_cmd(CMD_LOOKUP, 32'h0000_0000, 6'd17, $urandom, $urandom, 8'd0, 3'd0);
        drive_cmd(CMD_ADD, 32'h0A01_1234, 6'd16, 32'h1111_1111, 32'd3, 8'd5, 3'd5);
        drive_cmd(CMD_LOOKUP, 32'h0A01_0000, 6'd0, $urandom, $urandom, 8'd0, 3'd0);
        drive_cmd(CMD_DEL, 32'h0A01_0000, 6'd16, $urandom, $urandom, 8'd0, 3'd2);
        drive_cmd(CMD_DEL, 32'h0A01_ABCD, 6'd16, $urandom, $urandom, 8'd0, 3'd5);
        drive_cmd(CMD_LOOKUP, 32'h0A01_0000, 6'd0, $urandom, $urandom, 8'd0, 3'd0);
        drive_cmd(CMD_ADD, 32'h0102_0304, 6'd33, $urandom, $urandom, 8'd9, 3'd1);
        drive_cmd(CMD_DEL, 32'h0102_0304, 6'd63, $urandom, $urandom, 8'd9, 3'd1);
        drive_cmd(CMD_ADD, 32'h0102_0304, 6'd48, $urandom, $urandom, 8'd9, 3'd1);
        drive_cmd(CMD_SPARE, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 3'd7);
        drive_cmd(CMD_DEL, 32'h0000_0000, 6'd0, $urandom, $urandom, 8'd0, 3'd7);
        drive_cmd(CMD_LOOKUP, 32'h0000_0001, 6'd0, $urandom, $urandom, 8'd0, 3'd0);
        drive_cmd(CMD_DEL, 32'hFFFF_FFFF, 6'd32, $urandom, $urandom, 8'd0, 3'd0);
        drive_cmd(CMD_DEL, 32'hFFFF_FFFF, 6'd32, $urandom, $urandom, 8'd0, 3'd0);
        drive_cmd(CMD_LOOKUP, 32'h0A00_0000, 6'd0, $urandom, $urandom, 8'd0, 3'd0);
        drive_cmd(CMD_ADD, 32'h8000_0000, 6'd1, 32'h0A0A_0A0A, 32'd4, 8'd110, 3'd3);
        drive_cmd(CMD_LOOKUP, 32'hC000_0000, 6'd0, $urandom, $urandom, 8'd0, 3'd0);

        // fill, churn, drain, churn under changing throttling
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct <= 0;
                    stall_pct     <= 0;
                    add_w = 55;
                    del_w = 10;
                end
                1:
                begin
                    send_idle_pct <= 64;
                    stall_pct     <= 0;
                    add_w = 35;
                    del_w = 25;
                end
                2:
                begin
                    send_idle_pct <= 0;
                    stall_pct     <= 64;
                    hold_req      <= 1'b1;
                    add_w = 20;
                    del_w = 45;
                end
                default:
                begin
                    send_idle_pct <= 6;
                    stall_pct     <= 6;
                    add_w = 40;
                    del_w = 25;
                end
            endcase
            repeat (205) issue_random(add_w, del_w);
        end
        in_valid <= 1'b0;

        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/lpm_pkg.sv
sv/lpm_ram.sv
sv/lpm_match.sv
sv/ipv4_lpm_route_table_core.sv
sv/lpm_checker.sv
test/tb_ipv4_lpm_route_table_core.sv
